// ----- hw/rtl/osdfm_pkg.sv -----
// Shared types and constants for the OSD font memory register unit.
// Used by osdfm_ctrl, osdfm_datapath and osd_font_memory_registers_unit.
package osdfm_pkg;

  localparam int SHADOW_DEPTH = 64;
  localparam int SH_AW        = 6;
  localparam int CNT_W        = 7;   // holds 0..SHADOW_DEPTH

  // Register codes of a frame
  localparam logic [7:0] CODE_MODE_W  = 8'h00;
  localparam logic [7:0] CODE_CMD_W   = 8'h08;
  localparam logic [7:0] CODE_CADDR_W = 8'h09;
  localparam logic [7:0] CODE_BADDR_W = 8'h0a;
  localparam logic [7:0] CODE_DIN_W   = 8'h0b;
  localparam logic [7:0] CODE_MODE_R  = 8'h80;
  localparam logic [7:0] CODE_STAT_R  = 8'ha0;
  localparam logic [7:0] CODE_DOUT_R  = 8'hc0;
  localparam logic [7:0] CODE_PROBE_R = 8'h8c;

  // Memory command values
  localparam logic [7:0] OP_TO_STORE  = 8'ha0;
  localparam logic [7:0] OP_TO_SHADOW = 8'h50;

  localparam logic [7:0] STAT_BUSY_BIT = 8'h20;
  localparam logic [7:0] PROBE_VALUE   = 8'h1b;

  localparam logic [15:0] BUSY_TICKS_RST = 16'd12;

  typedef struct packed {
    logic       req_type;
    logic [7:0] cmd_byte;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nvm_busy;
    logic       rejected;
  } out_item_t;

  typedef enum logic [3:0] {
    CL_TICK,
    CL_MODE_W,
    CL_CMD_W,
    CL_CADDR_W,
    CL_BADDR_W,
    CL_DIN_W,
    CL_MODE_R,
    CL_STAT_R,
    CL_DOUT_R,
    CL_PROBE_R,
    CL_UNKNOWN
  } code_class_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_MODE,
    RD_STAT,
    RD_PROBE,
    RD_SHADOW
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDOUT,
    S_REDUCE,
    S_COPY,
    S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic    latch_item;
    logic    dec_busy;
    logic    wr_mode;
    logic    wr_caddr;
    logic    wr_baddr;
    logic    wr_din;
    logic    set_rej;
    rd_sel_t rd_sel;
    logic    row_sub;
    logic    copy_start;
    logic    copy_step;
    logic    copy_finish;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    code_class_t cls;
    logic        busy;
    logic        op_valid;
    logic        row_big;
    logic        copy_done;
    logic        out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/osdfm_ctrl.sv -----
// Controller of the OSD font memory register unit: sequences one transaction
// at a time. Depends on osdfm_pkg; drives osdfm_datapath via dp_cmd_t.
module osdfm_ctrl import osdfm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_NONE;
    in_ready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_nxt      = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_RESULT;
        if (status.busy && status.cls inside {CL_CMD_W, CL_CADDR_W, CL_BADDR_W, CL_DIN_W}) begin
          cmd.set_rej = 1'b1;
        end else begin
          case (status.cls)
            CL_TICK:    cmd.dec_busy = 1'b1;
            CL_MODE_W:  cmd.wr_mode  = 1'b1;
            CL_CADDR_W: cmd.wr_caddr = 1'b1;
            CL_BADDR_W: cmd.wr_baddr = 1'b1;
            CL_DIN_W:   cmd.wr_din   = 1'b1;
            CL_CMD_W: begin
              if (status.op_valid) begin
                cmd.copy_start = 1'b1;
                state_nxt      = S_REDUCE;
              end else begin
                cmd.set_rej = 1'b1;
              end
            end
            CL_MODE_R:  cmd.rd_sel = RD_MODE;
            CL_STAT_R:  cmd.rd_sel = RD_STAT;
            CL_PROBE_R: cmd.rd_sel = RD_PROBE;
            CL_DOUT_R:  state_nxt  = S_RDOUT;
            default:    cmd.set_rej = 1'b1;
          endcase
        end
      end

      // Shadow read data is registered, so it arrives in the cycle after the address
      S_RDOUT: begin
        cmd.rd_sel = RD_SHADOW;
        state_nxt  = S_RESULT;
      end

      // Bring the character address into range before the copy
      S_REDUCE: begin
        if (status.row_big) begin
          cmd.row_sub = 1'b1;
        end else begin
          state_nxt = S_COPY;
        end
      end

      S_COPY: begin
        if (status.copy_done) begin
          cmd.copy_finish = 1'b1;
          state_nxt       = S_RESULT;
        end else begin
          cmd.copy_step = 1'b1;
        end
      end

      S_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/osdfm_datapath.sv -----
// Datapath of the OSD font memory register unit: registers, shadow row,
// font store, row copy engine and output register. Depends on osdfm_pkg.
module osdfm_datapath import osdfm_pkg::*; #(
  parameter int CHAR_COUNT     = 256,
  parameter int BYTES_PER_CHAR = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  localparam int ROW_W       = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1;
  localparam int STORE_AW    = ROW_W + SH_AW;
  localparam int STORE_DEPTH = CHAR_COUNT * SHADOW_DEPTH;

  // Architectural registers
  in_item_t    item_r;
  logic [7:0]  video_mode_r;
  logic [7:0]  char_idx_r;
  logic [SH_AW-1:0] byte_idx_r;
  logic [15:0] busy_left_r, busy_left_nxt;
  logic [15:0] busy_ticks_r;
  logic [7:0]  rd_r;
  logic        rej_r;

  // Copy engine
  logic [7:0]       row_r;
  logic             to_store_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_r;
  logic [SH_AW-1:0] pend_addr_r;
  logic             issue;

  // Memories and their valid bits
  logic [7:0]            shadow_mem [SHADOW_DEPTH];
  logic [7:0]            store_mem  [STORE_DEPTH];
  logic [SHADOW_DEPTH-1:0] sh_valid_r;
  logic [CHAR_COUNT-1:0]   row_valid_r;
  logic [7:0]            sh_q_r, st_q_r;
  logic                  sh_vq_r, st_vq_r;
  logic [7:0]            sh_rd, st_rd;

  logic [SH_AW-1:0]    sh_raddr, sh_waddr;
  logic [7:0]          sh_wdata;
  logic                sh_we;
  logic [STORE_AW-1:0] st_raddr, st_waddr;
  logic                st_we;
  logic [ROW_W-1:0]    row_sel;

  out_item_t out_item_r;
  logic      out_valid_r;

  code_class_t cls;

  // Decode the latched frame
  always_comb begin
    if (item_r.req_type) begin
      cls = CL_TICK;
    end else begin
      case (item_r.cmd_byte)
        CODE_MODE_W:  cls = CL_MODE_W;
        CODE_CMD_W:   cls = CL_CMD_W;
        CODE_CADDR_W: cls = CL_CADDR_W;
        CODE_BADDR_W: cls = CL_BADDR_W;
        CODE_DIN_W:   cls = CL_DIN_W;
        CODE_MODE_R:  cls = CL_MODE_R;
        CODE_STAT_R:  cls = CL_STAT_R;
        CODE_DOUT_R:  cls = CL_DOUT_R;
        CODE_PROBE_R: cls = CL_PROBE_R;
        default:      cls = CL_UNKNOWN;
      endcase
    end
  end

  assign row_sel = row_r[ROW_W-1:0];
  assign issue   = cnt_r < CNT_W'(BYTES_PER_CHAR);
  assign sh_rd   = sh_vq_r ? sh_q_r : 8'h00;
  assign st_rd   = st_vq_r ? st_q_r : 8'h00;

  always_comb begin
    status.cls       = cls;
    status.busy      = busy_left_r != 16'd0;
    status.op_valid  = (item_r.data_byte == OP_TO_STORE) ||
                       (item_r.data_byte == OP_TO_SHADOW);
    status.row_big   = {1'b0, row_r} >= 9'(CHAR_COUNT);
    status.copy_done = !issue && !pend_r;
    status.out_free  = !out_valid_r || out_ready;
  end

  // Memory port steering
  always_comb begin
    sh_raddr = cmd.copy_step ? cnt_r[SH_AW-1:0] : byte_idx_r;
    st_raddr = {row_sel, cnt_r[SH_AW-1:0]};
    st_waddr = {row_sel, pend_addr_r};
    st_we    = cmd.copy_step && pend_r && to_store_r;
    sh_we    = 1'b0;
    sh_waddr = byte_idx_r;
    sh_wdata = item_r.data_byte;
    if (cmd.wr_din) begin
      sh_we = 1'b1;
    end else if (cmd.copy_step && pend_r && !to_store_r) begin
      sh_we    = 1'b1;
      sh_waddr = pend_addr_r;
      sh_wdata = st_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_we) begin
      shadow_mem[sh_waddr] <= sh_wdata;
    end
    sh_q_r <= shadow_mem[sh_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= sh_rd;
    end
    st_q_r <= store_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    sh_vq_r <= sh_valid_r[sh_raddr];
    st_vq_r <= row_valid_r[row_sel];
  end

  always_comb begin
    busy_left_nxt = busy_left_r;
    if (cmd.dec_busy && busy_left_r != 16'd0) begin
      busy_left_nxt = busy_left_r - 16'd1;
    end else if (cmd.copy_finish) begin
      busy_left_nxt = busy_ticks_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_mode_r <= '0;
      char_idx_r   <= '0;
      byte_idx_r   <= '0;
      busy_left_r  <= '0;
      busy_ticks_r <= BUSY_TICKS_RST;
      sh_valid_r   <= '0;
      row_valid_r  <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_left_r <= busy_left_nxt;
      if (cfg_we) begin
        busy_ticks_r <= cfg_data;
      end
      if (cmd.wr_mode) begin
        video_mode_r <= item_r.data_byte;
      end
      if (cmd.wr_caddr) begin
        char_idx_r <= item_r.data_byte;
      end
      if (cmd.wr_baddr) begin
        byte_idx_r <= item_r.data_byte[SH_AW-1:0];
      end
      if (sh_we) begin
        sh_valid_r[sh_waddr] <= 1'b1;
      end
      if (cmd.copy_start) begin
        cnt_r  <= '0;
        pend_r <= 1'b0;
      end else if (cmd.copy_step) begin
        // Read byte cnt now, write it back in the next cycle
        pend_r      <= issue;
        pend_addr_r <= cnt_r[SH_AW-1:0];
        if (issue) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.copy_finish && to_store_r) begin
        row_valid_r[row_sel] <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_r <= in_item;
      rd_r   <= '0;
      rej_r  <= 1'b0;
    end else begin
      if (cmd.set_rej) begin
        rej_r <= 1'b1;
      end
      case (cmd.rd_sel)
        RD_MODE:   rd_r <= video_mode_r;
        RD_STAT:   rd_r <= (busy_left_r != 16'd0) ? STAT_BUSY_BIT : 8'h00;
        RD_PROBE:  rd_r <= PROBE_VALUE;
        RD_SHADOW: rd_r <= sh_rd;
        default:   rd_r <= rd_r;
      endcase
    end
    if (cmd.copy_start) begin
      row_r      <= char_idx_r;
      to_store_r <= item_r.data_byte == OP_TO_STORE;
    end else if (cmd.row_sub) begin
      row_r <= 8'({1'b0, row_r} - 9'(CHAR_COUNT));
    end
    if (cmd.load_out) begin
      out_item_r.read_data <= rd_r;
      out_item_r.nvm_busy  <= busy_left_r != 16'd0;
      out_item_r.rejected  <= rej_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- hw/rtl/osd_font_memory_registers_unit.sv -----
// Top level of the OSD font memory register unit.
// Depends on osdfm_pkg, osdfm_ctrl and osdfm_datapath.
//
// Takes one transaction at a time: a register frame (or a busy tick) is
// accepted, executed and its single result placed in an output register; a
// data-out read also waits on the registered shadow read. A copy command
// first folds the character address into range (by repeated subtraction
// when CHAR_COUNT is small), then runs a byte-wide copy of BYTES_PER_CHAR
// bytes between the 64-byte shadow memory and the font store memory, which
// share one read and one write per cycle. The next transaction is accepted
// while a result waits on out_ready. Reset needs no clearing pass: per-row
// valid bits on the font store and per-byte valid bits on the shadow make
// unwritten bytes read as zero. The busy time register is written through
// the cfg_ port at any cycle.
module osd_font_memory_registers_unit import osdfm_pkg::*; #(
  parameter int CHAR_COUNT     = 256,
  parameter int BYTES_PER_CHAR = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  osdfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  osdfm_datapath #(
    .CHAR_COUNT     (CHAR_COUNT),
    .BYTES_PER_CHAR (BYTES_PER_CHAR)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
